// File: hdl/pwe_pkg.sv
// Shared constants and types for the pooling window engine.
package pwe_pkg;

    localparam int MAX_SIDE     = 64;
    localparam int MAX_KERNEL   = 8;
    localparam int SAMPLE_WIDTH = 16;

    localparam int SIDE_W  = $clog2(MAX_SIDE);
    localparam int ADDR_W  = 2 * SIDE_W;
    localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int KCNT_W  = $clog2(MAX_KERNEL);
    localparam int SUM_W   = SAMPLE_WIDTH + $clog2(MAX_KERNEL * MAX_KERNEL);
    localparam int DVSR_W  = 7;

    // register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_KERNEL = 3'd1;
    localparam logic [2:0] REG_STRIDE = 3'd2;
    localparam logic [2:0] REG_PAD    = 3'd3;
    localparam logic [2:0] REG_SIDE   = 3'd4;

    // input word kinds
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: hdl/pwe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module pwe_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pwe_pkg::t_div_req i_req,
    output pwe_pkg::t_div_rsp o_rsp
);
    import pwe_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_quo;
    logic [DVSR_W:0]   r_rem;
    logic [DVSR_W:0]   r_dvsr;
    logic [DVSR_W:0]   rem_shift;
    logic              fits;

    assign rem_shift = {r_rem[DVSR_W-1:0], r_quo[SUM_W-1]};
    assign fits      = (rem_shift >= r_dvsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvsr <= {1'b0, i_req.divisor};
            end else if (r_busy) begin
                r_rem <= fits ? (rem_shift - r_dvsr) : rem_shift;
                r_quo <= {r_quo[SUM_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: hdl/pooling_window_engine.sv
// Top level: feature map store, window sequencer and result register.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/tready         tdata: row, col, sample; tuser: func
//  m_axis    out  m_axis_tvalid/tready         tdata: pooled_value; tuser: out_of_range
//  apb       in   psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A load word is written into the map and leaves the input ready. A request runs
// the output size divide, a scan of k*k map reads (one memory read port), and in
// average mode a divide by k*k.
// Synchronous active-low reset; the map is not cleared.
// A pending result waits in the output register while new load words go in.
module pooling_window_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [5:0] row_index, [11:6] col_index, [27:12] sample_value
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pooled_value
    output logic        m_axis_tuser,   // [0] out_of_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pwe_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_OSZ   = 9'b000000010,
        ST_OWAIT = 9'b000000100,
        ST_CHK   = 9'b000001000,
        ST_SCAN  = 9'b000010000,
        ST_DRAIN = 9'b000100000,
        ST_FIN   = 9'b001000000,
        ST_AWAIT = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    t_state r_state;

    logic [1:0] r_mode;
    logic [3:0] r_kernel;
    logic [3:0] r_stride;
    logic [2:0] r_pad;
    logic [6:0] r_side;

    logic signed [SAMPLE_WIDTH-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_mem_q;

    logic [SIDE_W-1:0] r_row;
    logic [SIDE_W-1:0] r_col;
    logic [6:0]        r_osize;
    logic signed [11:0] r_left;
    logic signed [11:0] r_cur_row;
    logic signed [11:0] r_cur_col;
    logic [KCNT_W-1:0]  r_i;
    logic [KCNT_W-1:0]  r_j;
    logic               r_pend;
    logic               r_inmap;
    logic signed [SAMPLE_WIDTH-1:0] r_max;
    logic signed [SAMPLE_WIDTH-1:0] r_min;
    logic signed [SUM_W-1:0]        r_sum;
    logic                           r_neg;

    logic [SAMPLE_WIDTH-1:0] r_res_data;
    logic                    r_res_oor;

    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_data;
    logic                    r_out_oor;

    logic [3:0]  k_eff;
    logic [3:0]  s_eff;
    logic [6:0]  side_eff;
    logic [6:0]  span;
    logic [6:0]  kk;
    logic [9:0]  prod_row;
    logic [9:0]  prod_col;
    logic signed [11:0] top_row;
    logic signed [11:0] top_col;
    logic        in_map;
    logic        acc_en;
    logic        cfg_wr;
    logic        in_fire;
    logic [SUM_W-1:0]        abs_sum;
    logic [SUM_W-1:0]        avg_q;
    logic [ADDR_W-1:0]       rd_addr;

    t_div_req div_req;
    t_div_rsp div_rsp;

    pwe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 2'd0;
            r_kernel <= 4'd2;
            r_stride <= 4'd2;
            r_pad    <= 3'd0;
            r_side   <= 7'd64;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_MODE:   r_mode   <= pwdata[1:0];
                REG_KERNEL: r_kernel <= pwdata[3:0];
                REG_STRIDE: r_stride <= pwdata[3:0];
                REG_PAD:    r_pad    <= pwdata[2:0];
                REG_SIDE:   r_side   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MODE:   prdata = {30'd0, r_mode};
            REG_KERNEL: prdata = {28'd0, r_kernel};
            REG_STRIDE: prdata = {28'd0, r_stride};
            REG_PAD:    prdata = {29'd0, r_pad};
            REG_SIDE:   prdata = {25'd0, r_side};
            default:    prdata = 32'd0;
        endcase
    end

    // effective geometry
    always_comb begin
        if (r_kernel == 4'd0)
            k_eff = 4'd1;
        else if (r_kernel > 4'(MAX_KERNEL))
            k_eff = 4'(MAX_KERNEL);
        else
            k_eff = r_kernel;
        s_eff = (r_stride == 4'd0) ? 4'd1 : r_stride;
        if (r_side == 7'd0)
            side_eff = 7'd1;
        else if (r_side > 7'(MAX_SIDE))
            side_eff = 7'(MAX_SIDE);
        else
            side_eff = r_side;
    end

    assign span     = side_eff + {3'd0, r_pad, 1'b0};
    assign kk       = {3'd0, k_eff} * {3'd0, k_eff};
    assign prod_row = {4'd0, r_row} * {6'd0, s_eff};
    assign prod_col = {4'd0, r_col} * {6'd0, s_eff};
    assign top_row  = $signed({2'b00, prod_row}) - $signed({9'd0, r_pad});
    assign top_col  = $signed({2'b00, prod_col}) - $signed({9'd0, r_pad});

    assign in_map = !r_cur_row[11] && !r_cur_col[11]
                 && (r_cur_row < $signed({5'd0, side_eff}))
                 && (r_cur_col < $signed({5'd0, side_eff}));
    assign rd_addr = {r_cur_row[SIDE_W-1:0], r_cur_col[SIDE_W-1:0]};
    assign acc_en  = r_pend && r_inmap;

    assign abs_sum = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign avg_q   = r_neg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        div_req = '0;
        if (r_state == ST_OSZ && span >= {3'd0, k_eff}) begin
            div_req.start    = 1'b1;
            div_req.dividend = SUM_W'(span - {3'd0, k_eff});
            div_req.divisor  = DVSR_W'(s_eff);
        end else if (r_state == ST_FIN && r_mode[1]) begin
            div_req.start    = 1'b1;
            div_req.dividend = abs_sum;
            div_req.divisor  = kk;
        end
    end

    // feature map
    always_ff @(posedge i_clk) begin
        if (in_fire && s_axis_tuser == FUNC_LOAD)
            r_mem[{s_axis_tdata[5:0], s_axis_tdata[11:6]}] <= s_axis_tdata[27:12];
        r_mem_q <= r_mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (r_state == ST_OUT && (!r_out_valid || m_axis_tready))
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
            r_pend <= (r_state == ST_SCAN);

            if (acc_en) begin
                if (r_mem_q > r_max) r_max <= r_mem_q;
                if (r_mem_q < r_min) r_min <= r_mem_q;
                r_sum <= r_sum + SUM_W'(r_mem_q);
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_fire && s_axis_tuser == FUNC_REQUEST) begin
                        r_row   <= s_axis_tdata[5:0];
                        r_col   <= s_axis_tdata[11:6];
                        r_state <= ST_OSZ;
                    end
                end
                ST_OSZ: begin
                    if (span < {3'd0, k_eff}) begin
                        r_osize <= 7'd0;
                        r_state <= ST_CHK;
                    end else begin
                        r_state <= ST_OWAIT;
                    end
                end
                ST_OWAIT: begin
                    if (div_rsp.done) begin
                        r_osize <= div_rsp.quotient[6:0] + 7'd1;
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if ({1'b0, r_row} >= r_osize || {1'b0, r_col} >= r_osize) begin
                        r_res_data <= '0;
                        r_res_oor  <= 1'b1;
                        r_state    <= ST_OUT;
                    end else begin
                        r_cur_row <= top_row;
                        r_cur_col <= top_col;
                        r_left    <= top_col;
                        r_i       <= '0;
                        r_j       <= '0;
                        r_max     <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                        r_min     <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                        r_sum     <= '0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_inmap <= in_map;
                    if (r_j == KCNT_W'(k_eff - 4'd1)) begin
                        r_j       <= '0;
                        r_cur_col <= r_left;
                        r_i       <= r_i + 1'b1;
                        r_cur_row <= r_cur_row + 12'sd1;
                        if (r_i == KCNT_W'(k_eff - 4'd1))
                            r_state <= ST_DRAIN;
                    end else begin
                        r_j       <= r_j + 1'b1;
                        r_cur_col <= r_cur_col + 12'sd1;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_res_oor <= 1'b0;
                    r_neg     <= r_sum[SUM_W-1];
                    if (r_mode[1]) begin
                        r_state <= ST_AWAIT;
                    end else begin
                        r_res_data <= r_mode[0] ? r_min : r_max;
                        r_state    <= ST_OUT;
                    end
                end
                ST_AWAIT: begin
                    if (div_rsp.done) begin
                        r_res_data <= avg_q[SAMPLE_WIDTH-1:0];
                        r_state    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data <= r_res_data;
                        r_out_oor  <= r_res_oor;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_oor;

endmodule

// File: hdl/pwe_checker.sv
// Port-level checks for the pooling window engine, bound to the top level.
module pwe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import pwe_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
        else $error("out-of-range result carries nonzero data");

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_REQUEST |=> !s_axis_tready)
        else $error("ready after request word");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_LOAD |=> s_axis_tready)
        else $error("load word stalled input");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind pooling_window_engine pwe_checker u_pwe_checker (.*);
